FILE: rtl/dbrt_pkg.sv
// Shared constants and types for the double-buffer dirty rectangle tracker.
package dbrt_pkg;

   localparam int MAX_RECTS_DEF  = 12;
   localparam int COORD_BITS_DEF = 11;

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 12;

   localparam logic [CSR_DATA_W-1:0] CANVAS_SIZE_RESET = 12'd2048;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_CANVAS_WIDTH  = 2'd0,
      CSR_CANVAS_HEIGHT = 2'd1
   } csr_index_type;

   typedef enum logic [1:0] {
      KIND_NEW    = 2'd0,
      KIND_REPLAY = 2'd1,
      KIND_FULL   = 2'd2
   } blit_kind_type;

endpackage

FILE: rtl/dbrt_rect_mem.sv
// Ping-pong rectangle table: one write port, one registered read port.
module dbrt_rect_mem #(
   parameter int ADDR_W = $clog2(dbrt_pkg::MAX_RECTS_DEF) + 1,
   parameter int DATA_W = 4 * dbrt_pkg::COORD_BITS_DEF
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem [2**ADDR_W];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/double_buffer_dirty_rect_tracker.sv
// Double-buffer dirty rectangle tracker: top level with replay sequencer.
// Each word gives its new-rectangle blit in the cycle after acceptance; the next word
// is taken once that result has left the output register. At frame end a full-canvas
// blit or a replay of the stored rectangles may follow; each replayed rectangle takes
// one table read and one output load through the single read port.
// Synchronous reset clears the sequencer, counts and flags; the tables are not cleared.
module double_buffer_dirty_rect_tracker #(
   parameter int MAX_RECTS  = dbrt_pkg::MAX_RECTS_DEF,
   parameter int COORD_BITS = dbrt_pkg::COORD_BITS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [COORD_BITS-1:0]            req_rect_left,
   input  logic [COORD_BITS-1:0]            req_rect_top,
   input  logic [COORD_BITS-1:0]            req_rect_right,
   input  logic [COORD_BITS-1:0]            req_rect_bottom,
   input  logic                             req_frame_end,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [COORD_BITS-1:0]            rsp_out_left,
   output logic [COORD_BITS-1:0]            rsp_out_top,
   output logic [COORD_BITS-1:0]            rsp_out_right,
   output logic [COORD_BITS-1:0]            rsp_out_bottom,
   output logic                             rsp_target_buffer,
   output dbrt_pkg::blit_kind_type          rsp_blit_kind,
   output logic                             rsp_flip_now,
   output logic                             rsp_last_result,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [dbrt_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [dbrt_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   import dbrt_pkg::*;

   localparam int IDX_W  = (MAX_RECTS > 1) ? $clog2(MAX_RECTS) : 1;
   localparam int CNT_W  = $clog2(MAX_RECTS + 1);
   localparam int ADDR_W = IDX_W + 1;
   localparam int RECT_W = 4 * COORD_BITS;
   localparam int SZ_W   = (COORD_BITS + 1 > CSR_DATA_W) ? COORD_BITS + 1 : CSR_DATA_W;
   localparam logic [COORD_BITS-1:0] COORD_MASK = '1;
   localparam logic [CNT_W-1:0]      MAX_CNT    = CNT_W'(MAX_RECTS);

   typedef enum logic [1:0] {
      S_IDLE,
      S_FULL,
      S_RD,
      S_RPL
   } state_type;

   state_type               state_ff;
   logic                    cur_sel_ff;
   logic [CNT_W-1:0]        cur_cnt_ff;
   logic                    cur_ovf_ff;
   logic [CNT_W-1:0]        prev_cnt_ff;
   logic                    prev_full_ff;
   logic                    back_ff;
   logic [CSR_DATA_W-1:0]   width_ff;
   logic [CSR_DATA_W-1:0]   height_ff;
   logic [IDX_W-1:0]        idx_ff;

   logic                    rsp_valid_ff;
   logic [COORD_BITS-1:0]   rsp_left_ff;
   logic [COORD_BITS-1:0]   rsp_top_ff;
   logic [COORD_BITS-1:0]   rsp_right_ff;
   logic [COORD_BITS-1:0]   rsp_bottom_ff;
   logic                    rsp_target_ff;
   blit_kind_type           rsp_kind_ff;
   logic                    rsp_flip_ff;
   logic                    rsp_last_ff;

   logic                    accept;
   logic                    out_free;
   logic                    rsp_load;
   logic                    store;
   logic [CNT_W-1:0]        cnt_in;
   logic                    ovf_in;
   logic                    no_catch;
   logic                    rpl_last;
   logic [COORD_BITS-1:0]   full_right;
   logic [COORD_BITS-1:0]   full_bottom;
   logic                    mem_wr_en;
   logic [ADDR_W-1:0]       mem_wr_addr;
   logic [RECT_W-1:0]       mem_wr_data;
   logic                    mem_rd_en;
   logic [ADDR_W-1:0]       mem_rd_addr;
   logic [RECT_W-1:0]       mem_rd_data;

   // Saturate the canvas size to 1..2^COORD_BITS, then take the last coordinate.
   function automatic logic [COORD_BITS-1:0] last_coord(input logic [CSR_DATA_W-1:0] size);
      logic [CSR_DATA_W-1:0] size_m1;
      logic [SZ_W-1:0]       size_ext;
      size_m1  = (size == '0) ? '0 : size - 1'b1;
      size_ext = SZ_W'(size_m1);
      return (size_ext > SZ_W'(COORD_MASK)) ? COORD_MASK : size_ext[COORD_BITS-1:0];
   endfunction

   assign req_ready = (state_ff == S_IDLE) && !rsp_valid_ff;
   assign csr_ready = 1'b1;
   assign accept    = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_load  = (state_ff == S_IDLE) ? accept :
                      ((state_ff == S_FULL || state_ff == S_RPL) && out_free);

   assign store    = !cur_ovf_ff && (cur_cnt_ff < MAX_CNT);
   assign cnt_in   = store ? cur_cnt_ff + 1'b1 : cur_cnt_ff;
   assign ovf_in   = cur_ovf_ff || !store;
   assign no_catch = !prev_full_ff && (prev_cnt_ff == '0);
   assign rpl_last = (CNT_W'(idx_ff) == prev_cnt_ff - 1'b1);

   assign full_right  = last_coord(width_ff);
   assign full_bottom = last_coord(height_ff);

   assign mem_wr_en   = accept && store;
   assign mem_wr_addr = {cur_sel_ff, cur_cnt_ff[IDX_W-1:0]};
   assign mem_wr_data = {req_rect_left, req_rect_top, req_rect_right, req_rect_bottom};
   assign mem_rd_en   = (state_ff == S_RD);
   assign mem_rd_addr = {~cur_sel_ff, idx_ff};

   dbrt_rect_mem #(
      .ADDR_W (ADDR_W),
      .DATA_W (RECT_W)
   ) u_rect_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cur_sel_ff   <= 1'b0;
         cur_cnt_ff   <= '0;
         cur_ovf_ff   <= 1'b0;
         prev_cnt_ff  <= '0;
         prev_full_ff <= 1'b1;
         back_ff      <= 1'b1;
         width_ff     <= CANVAS_SIZE_RESET;
         height_ff    <= CANVAS_SIZE_RESET;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_CANVAS_WIDTH:  width_ff  <= csr_wdata;
               CSR_CANVAS_HEIGHT: height_ff <= csr_wdata;
               default: ;
            endcase
         end

         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end

         unique case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  rsp_left_ff   <= req_rect_left;
                  rsp_top_ff    <= req_rect_top;
                  rsp_right_ff  <= req_rect_right;
                  rsp_bottom_ff <= req_rect_bottom;
                  rsp_target_ff <= back_ff;
                  rsp_kind_ff   <= KIND_NEW;
                  rsp_flip_ff   <= req_frame_end && no_catch;
                  rsp_last_ff   <= !req_frame_end || no_catch;
                  if (req_frame_end && no_catch) begin
                     // nothing to catch up: flip straight away
                     back_ff      <= ~back_ff;
                     cur_sel_ff   <= ~cur_sel_ff;
                     prev_cnt_ff  <= cnt_in;
                     prev_full_ff <= ovf_in;
                     cur_cnt_ff   <= '0;
                     cur_ovf_ff   <= 1'b0;
                  end else begin
                     cur_cnt_ff <= cnt_in;
                     cur_ovf_ff <= ovf_in;
                     if (req_frame_end) begin
                        if (prev_full_ff) begin
                           state_ff <= S_FULL;
                        end else begin
                           idx_ff   <= '0;
                           state_ff <= S_RD;
                        end
                     end
                  end
               end
            end
            S_FULL: begin
               if (out_free) begin
                  rsp_left_ff   <= '0;
                  rsp_top_ff    <= '0;
                  rsp_right_ff  <= full_right;
                  rsp_bottom_ff <= full_bottom;
                  rsp_target_ff <= back_ff;
                  rsp_kind_ff   <= KIND_FULL;
                  rsp_flip_ff   <= 1'b1;
                  rsp_last_ff   <= 1'b1;
                  back_ff       <= ~back_ff;
                  cur_sel_ff    <= ~cur_sel_ff;
                  prev_cnt_ff   <= cur_cnt_ff;
                  prev_full_ff  <= cur_ovf_ff;
                  cur_cnt_ff    <= '0;
                  cur_ovf_ff    <= 1'b0;
                  state_ff      <= S_IDLE;
               end
            end
            S_RD: begin
               state_ff <= S_RPL;
            end
            S_RPL: begin
               if (out_free) begin
                  rsp_left_ff   <= mem_rd_data[4*COORD_BITS-1:3*COORD_BITS];
                  rsp_top_ff    <= mem_rd_data[3*COORD_BITS-1:2*COORD_BITS];
                  rsp_right_ff  <= mem_rd_data[2*COORD_BITS-1:COORD_BITS];
                  rsp_bottom_ff <= mem_rd_data[COORD_BITS-1:0];
                  rsp_target_ff <= back_ff;
                  rsp_kind_ff   <= KIND_REPLAY;
                  rsp_flip_ff   <= rpl_last;
                  rsp_last_ff   <= rpl_last;
                  if (rpl_last) begin
                     back_ff      <= ~back_ff;
                     cur_sel_ff   <= ~cur_sel_ff;
                     prev_cnt_ff  <= cur_cnt_ff;
                     prev_full_ff <= cur_ovf_ff;
                     cur_cnt_ff   <= '0;
                     cur_ovf_ff   <= 1'b0;
                     state_ff     <= S_IDLE;
                  end else begin
                     idx_ff   <= idx_ff + 1'b1;
                     state_ff <= S_RD;
                  end
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_out_left      = rsp_left_ff;
   assign rsp_out_top       = rsp_top_ff;
   assign rsp_out_right     = rsp_right_ff;
   assign rsp_out_bottom    = rsp_bottom_ff;
   assign rsp_target_buffer = rsp_target_ff;
   assign rsp_blit_kind     = rsp_kind_ff;
   assign rsp_flip_now      = rsp_flip_ff;
   assign rsp_last_result   = rsp_last_ff;

   // a new word never lands on a result still waiting
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      accept |-> !rsp_valid_ff)
      else $error("word accepted while a result is pending");

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cur_cnt_ff <= MAX_CNT)
      else $error("current count beyond table depth");

   a_ovf_full: assert property (@(posedge clock) disable iff (reset)
      cur_ovf_ff |-> (cur_cnt_ff == MAX_CNT))
      else $error("overflow flagged with table not full");

   a_flip_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_flip_ff) |-> rsp_last_ff)
      else $error("flip on a result that is not the last");

   a_replay_src: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_RD || state_ff == S_RPL) |-> (!prev_full_ff && prev_cnt_ff != '0))
      else $error("replay without a valid previous list");

endmodule

FILE: sim/tb.sv
// Self-checking testbench for the double-buffer dirty rectangle tracker.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import dbrt_pkg::*;

   localparam int CB = COORD_BITS_DEF;
   localparam int MR = MAX_RECTS_DEF;
   localparam int CYCLE_LIMIT = 200000;
   localparam int PHASES = 5;
   localparam int WORDS_PER_PHASE = 53;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED_IDX = 2'd3;
   localparam logic [CB-1:0] COORD_MAX = '1;

   typedef struct packed {
      logic [CB-1:0] left;
      logic [CB-1:0] top;
      logic [CB-1:0] right;
      logic [CB-1:0] bottom;
   } rect_type;

   typedef struct {
      rect_type      rect;
      logic          target;
      blit_kind_type kind;
      logic          flip;
      logic          last;
   } blit_type;

   typedef enum {RX_ALWAYS, RX_COIN, RX_ONE_IN_FOUR, RX_MOSTLY} rx_mode_type;

   class dirty_rect_scoreboard;
      rect_type              rect_store [2][MR];
      bit                    cur_sel;
      int unsigned           cur_count;
      bit                    cur_overflow;
      int unsigned           prev_count;
      bit                    prev_full;
      bit                    back_buf;
      logic [CSR_DATA_W-1:0] width_reg;
      logic [CSR_DATA_W-1:0] height_reg;
      blit_type              blits_due [$];
      int                    mismatches;

      function new();
         cur_sel      = 1'b0;
         cur_count    = 0;
         cur_overflow = 1'b0;
         prev_count   = 0;
         prev_full    = 1'b1;
         back_buf     = 1'b1;
         width_reg    = CANVAS_SIZE_RESET;
         height_reg   = CANVAS_SIZE_RESET;
         mismatches   = 0;
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
         if (idx == CSR_CANVAS_WIDTH) width_reg = val;
         else if (idx == CSR_CANVAS_HEIGHT) height_reg = val;
      endfunction

      // canvas size clamped to 1..2^CB, then the last pixel index
      function logic [CB-1:0] last_coord(logic [CSR_DATA_W-1:0] size);
         int s;
         s = size;
         if (s < 1) s = 1;
         if (s > (1 << CB)) s = 1 << CB;
         return CB'(s - 1);
      endfunction

      function int pending();
         return blits_due.size();
      endfunction

      function void note_rect(rect_type r, bit frame_end);
         blit_type b;
         int       total;
         total = 1;
         if (frame_end) total += prev_full ? 1 : prev_count;
         for (int k = 0; k < total; k++) begin
            if (k == 0) begin
               b.rect = r;
               b.kind = KIND_NEW;
            end else if (prev_full) begin
               b.rect.left   = '0;
               b.rect.top    = '0;
               b.rect.right  = last_coord(width_reg);
               b.rect.bottom = last_coord(height_reg);
               b.kind        = KIND_FULL;
            end else begin
               b.rect = rect_store[!cur_sel][k-1];
               b.kind = KIND_REPLAY;
            end
            b.target = back_buf;
            b.last   = (k == total - 1);
            b.flip   = frame_end && (k == total - 1);
            blits_due.push_back(b);
         end
         // once overflowed, nothing more is stored this frame
         if (!cur_overflow) begin
            if (cur_count < MR) begin
               rect_store[cur_sel][cur_count] = r;
               cur_count++;
            end else begin
               cur_overflow = 1'b1;
            end
         end
         if (frame_end) begin
            back_buf     ^= 1'b1;
            cur_sel      ^= 1'b1;
            prev_count   = cur_count;
            prev_full    = cur_overflow;
            cur_count    = 0;
            cur_overflow = 1'b0;
         end
      endfunction

      function string describe(blit_type b);
         return $sformatf("l=%0d t=%0d r=%0d b=%0d buf=%0d kind=%0d flip=%0d last=%0d",
                          b.rect.left, b.rect.top, b.rect.right, b.rect.bottom,
                          b.target, b.kind, b.flip, b.last);
      endfunction

      function void check_blit(blit_type got);
         blit_type want;
         if (blits_due.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected blit: got %s", describe(got));
            return;
         end
         want = blits_due.pop_front();
         if (got.rect !== want.rect || got.target !== want.target || got.kind !== want.kind ||
             got.flip !== want.flip || got.last !== want.last) begin
            mismatches++;
            if (mismatches <= 10)
               $display("blit mismatch: exp %s / got %s", describe(want), describe(got));
         end
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   logic [CB-1:0]         req_rect_left;
   logic [CB-1:0]         req_rect_top;
   logic [CB-1:0]         req_rect_right;
   logic [CB-1:0]         req_rect_bottom;
   logic                  req_frame_end;
   logic                  rsp_valid;
   logic                  rsp_ready;
   logic [CB-1:0]         rsp_out_left;
   logic [CB-1:0]         rsp_out_top;
   logic [CB-1:0]         rsp_out_right;
   logic [CB-1:0]         rsp_out_bottom;
   logic                  rsp_target_buffer;
   blit_kind_type         rsp_blit_kind;
   logic                  rsp_flip_now;
   logic                  rsp_last_result;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   dirty_rect_scoreboard sb = new();

   int          burst_left = 0;
   int          cycle_count = 0;
   int          rx_mode_cycles = 0;
   int          rx_tick = 0;
   rx_mode_type rx_mode = RX_ALWAYS;

   double_buffer_dirty_rect_tracker dut (.*);

   always #10 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb NOT OK");
         $finish;
      end
   end

   // receiver: stall pattern switches mode every so often
   always @(posedge clock) begin
      if (rx_mode_cycles == 0) begin
         rx_mode        = rx_mode_type'($urandom_range(0, 3));
         rx_mode_cycles = $urandom_range(20, 120);
      end
      rx_mode_cycles--;
      rx_tick++;
      case (rx_mode)
         RX_ALWAYS:      rsp_ready <= 1'b1;
         RX_COIN:        rsp_ready <= 1'($urandom_range(0, 1));
         RX_ONE_IN_FOUR: rsp_ready <= (rx_tick % 4 == 0);
         default:        rsp_ready <= ($urandom_range(0, 4) != 0);
      endcase
   end

   always @(posedge clock) begin
      blit_type seen;
      if (!reset && rsp_valid && rsp_ready) begin
         seen.rect.left   = rsp_out_left;
         seen.rect.top    = rsp_out_top;
         seen.rect.right  = rsp_out_right;
         seen.rect.bottom = rsp_out_bottom;
         seen.target      = rsp_target_buffer;
         seen.kind        = rsp_blit_kind;
         seen.flip        = rsp_flip_now;
         seen.last        = rsp_last_result;
         sb.check_blit(seen);
      end
   end

   function automatic logic [CB-1:0] rand_coord();
      case ($urandom_range(0, 7))
         0:       return '0;
         1:       return COORD_MAX;
         default: return CB'($urandom_range(0, COORD_MAX));
      endcase
   endfunction

   function automatic rect_type rand_rect();
      rect_type r;
      r.left   = rand_coord();
      r.top    = rand_coord();
      r.right  = rand_coord();
      r.bottom = rand_coord();
      return r;
   endfunction

   function automatic rect_type make_rect(int l, int t, int r, int b);
      rect_type x;
      x.left   = CB'(l);
      x.top    = CB'(t);
      x.right  = CB'(r);
      x.bottom = CB'(b);
      return x;
   endfunction

   // valid is only dropped at the start of a gap, so back-to-back words keep it high
   task automatic send_word(input rect_type r, input bit frame_end);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 16);
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid       <= 1'b1;
      req_rect_left   <= r.left;
      req_rect_top    <= r.top;
      req_rect_right  <= r.right;
      req_rect_bottom <= r.bottom;
      req_frame_end   <= frame_end;
      do @(posedge clock); while (!req_ready);
      sb.note_rect(r, frame_end);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      burst_left = 0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic program_canvas(input logic [CSR_DATA_W-1:0] w,
                                 input logic [CSR_DATA_W-1:0] h, input bit poke_unused);
      logic [CSR_IDX_W-1:0]  idx [3];
      logic [CSR_DATA_W-1:0] val [3];
      int                    n;
      idx[0] = CSR_CANVAS_WIDTH;
      val[0] = w;
      idx[1] = CSR_CANVAS_HEIGHT;
      val[1] = h;
      idx[2] = CSR_UNUSED_IDX;
      val[2] = CSR_DATA_W'($urandom);
      n = poke_unused ? 3 : 2;
      for (int k = 0; k < n; k++) begin
         csr_valid <= 1'b1;
         csr_index <= idx[k];
         csr_wdata <= val[k];
         do @(posedge clock); while (!csr_ready);
         sb.write_reg(idx[k], val[k]);
      end
      csr_valid <= 1'b0;
   endtask

   task automatic directed_frames();
      // first frame end after reset: full-canvas catch-up
      send_word(make_rect(0, 0, 0, 0), 1'b1);
      // corner extremes, then an inverted rectangle
      send_word(make_rect(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX), 1'b0);
      send_word(make_rect(COORD_MAX, 0, 0, COORD_MAX), 1'b1);
      // table overflow: two words past the capacity
      for (int i = 0; i < MR + 2; i++)
         send_word(make_rect(i * 97, 2047 - i * 61, i * 150, 2047 - i * 3), i == MR + 1);
      // previous frame overflowed: full-canvas catch-up again
      send_word(make_rect(5, 6, 7, 8), 1'b1);
   endtask

   task automatic random_frames(input int quota);
      int sent;
      int len;
      sent = 0;
      while (sent < quota) begin
         case ($urandom_range(0, 9))
            7:       len = MR;
            8, 9:    len = $urandom_range(MR + 1, MR + 4);
            6:       len = MR - 1;
            default: len = $urandom_range(1, 6);
         endcase
         for (int k = 0; k < len; k++) send_word(rand_rect(), k == len - 1);
         sent += len;
      end
   endtask

   initial begin
      reset           <= 1'b1;
      req_valid       <= 1'b0;
      req_rect_left   <= '0;
      req_rect_top    <= '0;
      req_rect_right  <= '0;
      req_rect_bottom <= '0;
      req_frame_end   <= 1'b0;
      rsp_ready       <= 1'b0;
      csr_valid       <= 1'b0;
      csr_index       <= CSR_CANVAS_WIDTH;
      csr_wdata       <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      for (int ph = 0; ph < PHASES; ph++) begin
         wait_drained();
         case (ph)
            0:       program_canvas(12'd2048, 12'd2048, 1'b0);
            1:       program_canvas(12'd1, 12'd1, 1'b0);
            2:       program_canvas(12'd0, 12'd4095, 1'b1);
            3:       program_canvas(12'd2049, 12'd2047, 1'b0);
            default: program_canvas(CSR_DATA_W'($urandom_range(0, 4095)),
                                    CSR_DATA_W'($urandom_range(0, 4095)), 1'b0);
         endcase
         if (ph == 0) directed_frames();
         random_frames(WORDS_PER_PHASE);
      end
      wait_drained();
      repeat (30) @(posedge clock);
      if (sb.mismatches == 0 && sb.pending() == 0)
         $display("tb OK");
      else
         $display("tb NOT OK");
      $finish;
   end

endmodule

FILE: files.f
rtl/dbrt_pkg.sv
rtl/dbrt_rect_mem.sv
rtl/double_buffer_dirty_rect_tracker.sv
sim/tb.sv
